FILE: src/lcs_pkg.sv
// ----------------------------------------------------------------------------
// lcs_pkg: shared types and constants for the LCS length engine
// Sizes of the reference row, symbol width, action codes, cell token and
// cell control bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package lcs_pkg;

  localparam int MAX_LEN = 256;
  localparam int LEN_W   = $clog2(MAX_LEN + 1);
  localparam int SYM_W   = 8;
  localparam int DIST_W  = LEN_W + 1;

  localparam logic ACT_REF   = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // one query symbol moving down the chain of cells
  typedef struct packed {
    logic             valid;
    logic             upd;
    logic             last;
    logic [SYM_W-1:0] sym;
    logic [LEN_W-1:0] diag;
    logic [LEN_W-1:0] left;
  } token_t;

  typedef struct packed {
    logic clear_row;
    logic flush;
    logic clear_active;
  } cell_ctl_t;

endpackage

`default_nettype wire

FILE: src/lcs_cell.sv
// ----------------------------------------------------------------------------
// lcs_cell: one reference position of the LCS row
// Holds one reference symbol and its DP value, updates the value from the
// passing query token and hands the token to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module lcs_cell
  import lcs_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire cell_ctl_t        ctl,
  input  wire logic             wr_en,
  input  wire logic [SYM_W-1:0] wr_sym,
  input  wire token_t           tok_in,
  output token_t                tok_out
);

  logic [SYM_W-1:0] sym;
  logic             active;
  logic [LEN_W-1:0] value;
  logic [LEN_W-1:0] value_next;
  logic             apply;
  logic             match;
  token_t           tok_next;

  always_comb begin
    match = (tok_in.sym == sym);
    if (match) begin
      value_next = tok_in.diag + LEN_W'(1);
    end else begin
      value_next = (value > tok_in.left) ? value : tok_in.left;
    end
    apply = tok_in.valid && tok_in.upd && active;

    tok_next       = tok_in;
    tok_next.diag  = value;
    if (active) begin
      tok_next.left = apply ? value_next : value;
    end else begin
      tok_next.left = tok_in.left;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      sym <= wr_sym;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (wr_en) begin
      active <= 1'b1;
    end else if (ctl.clear_active) begin
      active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear_row) begin
      value <= '0;
    end else if (apply) begin
      value <= value_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.flush) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_next.valid;
    end
    tok_out.upd  <= tok_next.upd;
    tok_out.last <= tok_next.last;
    tok_out.sym  <= tok_next.sym;
    tok_out.diag <= tok_next.diag;
    tok_out.left <= tok_next.left;
  end

endmodule

`default_nettype wire

FILE: src/lcs_length_engine.sv
// ----------------------------------------------------------------------------
// lcs_length_engine: longest common subsequence length against a reference
// Loads a reference string into a chain of cells, streams query symbols
// through the chain as a wavefront and reports LCS length, indel distance,
// query length and overflow at the end of each query.
//
//   channel   signals                                   transfer
//   input     start, busy, action, symbol, last         start && !busy
//   result    done, lcs_length, indel_distance,         done
//             query_length, overflow
//
// Reference and non-final query symbols: one per cycle, busy stays low.
// Final query symbol: its token walks the MAX_LEN-cell chain, through one
// register per cell, then done is registered; busy is high meanwhile.
// A reference symbol discards any query in flight and clears the row.
// Reset: synchronous, clears the row, counters and flags.
// The receiver cannot stall; done is high for one cycle per result.
// ----------------------------------------------------------------------------
`default_nettype none

module lcs_length_engine
  import lcs_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic              action,
  input  wire logic [SYM_W-1:0]  symbol,
  input  wire logic              last,
  output logic                   done,
  output logic [LEN_W-1:0]       lcs_length,
  output logic [DIST_W-1:0]      indel_distance,
  output logic [LEN_W-1:0]       query_length,
  output logic                   overflow
);

  logic             accept;
  logic             ref_wr;
  logic             qry_acc;
  logic [LEN_W-1:0] ref_count;
  logic [LEN_W-1:0] ref_count_eff;
  logic             ref_done;
  logic             ovf_seen;
  logic             ovf_base;
  logic [LEN_W-1:0] query_count;
  logic             q_room;
  logic             pending;
  logic [LEN_W-1:0] qlen_hold;
  logic             ovf_hold;
  logic             result_ready;
  logic [DIST_W-1:0] indel_calc;

  cell_ctl_t        ctl;
  logic [MAX_LEN-1:0] wr_vec;
  token_t           tok [MAX_LEN+1];

  assign busy    = pending;
  assign accept  = start && !pending;
  assign ref_wr  = accept && (action == ACT_REF);
  assign qry_acc = accept && (action == ACT_QUERY);

  assign ref_count_eff = ref_done ? '0 : ref_count;
  assign ovf_base      = ref_done ? 1'b0 : ovf_seen;
  assign q_room        = (query_count < LEN_W'(MAX_LEN));

  assign result_ready = tok[MAX_LEN].valid && tok[MAX_LEN].last;

  always_comb begin
    ctl.clear_row    = ref_wr || result_ready;
    ctl.flush        = ref_wr;
    ctl.clear_active = ref_wr && ref_done;
  end

  always_comb begin
    tok[0].valid = qry_acc;
    tok[0].upd   = q_room;
    tok[0].last  = last;
    tok[0].sym   = symbol;
    tok[0].diag  = '0;
    tok[0].left  = '0;
  end

  for (genvar j = 0; j < MAX_LEN; j++) begin : g_cell
    assign wr_vec[j] = ref_wr && (ref_count_eff == LEN_W'(j));

    lcs_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl),
      .wr_en   (wr_vec[j]),
      .wr_sym  (symbol),
      .tok_in  (tok[j]),
      .tok_out (tok[j+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_count   <= '0;
      ref_done    <= 1'b0;
      ovf_seen    <= 1'b0;
      query_count <= '0;
      pending     <= 1'b0;
    end else begin
      if (ref_wr) begin
        query_count <= '0;
        ref_done    <= last;
        if (ref_count_eff < LEN_W'(MAX_LEN)) begin
          ref_count <= ref_count_eff + LEN_W'(1);
          ovf_seen  <= ovf_base;
        end else begin
          ref_count <= ref_count_eff;
          ovf_seen  <= 1'b1;
        end
      end else if (qry_acc) begin
        if (!q_room) begin
          ovf_seen <= 1'b1;
        end
        if (last) begin
          query_count <= '0;
          pending     <= 1'b1;
        end else if (q_room) begin
          query_count <= query_count + LEN_W'(1);
        end
      end
      if (result_ready) begin
        pending <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (qry_acc && last) begin
      qlen_hold <= q_room ? query_count + LEN_W'(1) : query_count;
      ovf_hold  <= ovf_seen || !q_room;
    end
  end

  assign indel_calc = DIST_W'(qlen_hold) + DIST_W'(ref_count)
                    - {(DIST_W - LEN_W)'(0), tok[MAX_LEN].left}
                    - {(DIST_W - LEN_W)'(0), tok[MAX_LEN].left};

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= result_ready;
    end
    if (result_ready) begin
      lcs_length     <= tok[MAX_LEN].left;
      indel_distance <= indel_calc;
      query_length   <= qlen_hold;
      overflow       <= ovf_hold;
    end
  end

  a_done_after_pending: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(pending))
    else $error("result strobe without a pending query");

  a_done_frees_input: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("busy still high in result cycle");

  a_ref_count_bound: assert property (@(posedge clk) disable iff (rst)
    ref_count <= LEN_W'(MAX_LEN))
    else $error("reference count beyond maximum");

  a_lcs_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (lcs_length <= query_length) && (lcs_length <= ref_count))
    else $error("lcs length exceeds a string length");

endmodule

`default_nettype wire
